// File: rtl/kfhs_pkg.sv
`timescale 1ns / 1ps
package kfhs_pkg;

	typedef enum logic [2:0] {
		REG_KEY0      = 3'd0,
		REG_KEY1      = 3'd1,
		REG_KEY2      = 3'd2,
		REG_KEY3      = 3'd3,
		REG_RATIO     = 3'd4,
		REG_V4_MASK   = 3'd5,
		REG_V6_MASK_H = 3'd6,
		REG_V6_MASK_L = 3'd7
	} reg_idx_t;

	localparam logic [63:0] LEN_BITS_V4 = 64'd688;
	localparam logic [63:0] LEN_BITS_V6 = 64'd1312;
	localparam logic [63:0] LEN_BITS_OUTER = 64'd768;
	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [24:0] RATIO_LIMIT = 25'h1000000;

	typedef struct packed {
		logic         v6;
		logic [1023:0] tail;
	} entry_t;

	typedef struct packed {
		logic         start;
		logic [255:0] init;
		logic [511:0] block;
	} sha_req_t;

	typedef struct packed {
		logic         done;
		logic [255:0] hash;
	} sha_rsp_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		c = (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
		return c;
	endfunction

endpackage

// File: rtl/kfhs_if.sv
`timescale 1ns / 1ps
interface kfhs_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] source_high;
	logic [63:0] source_low;
	logic [63:0] dest_high;
	logic [63:0] dest_low;
	logic [15:0] dest_port;

	modport source (output valid, mode, source_high, source_low, dest_high, dest_low,
		dest_port, input ready);
	modport sink (input valid, mode, source_high, source_low, dest_high, dest_low,
		dest_port, output ready);
endinterface

interface kfhs_out_if;
	logic        valid;
	logic        ready;
	logic        selected;
	logic [23:0] residue;

	modport source (output valid, selected, residue, input ready);
	modport sink (input valid, selected, residue, output ready);
endinterface

// File: rtl/kfhs_front.sv
`timescale 1ns / 1ps
module kfhs_front (
	kfhs_in_if.sink          pkt,
	input  logic [31:0]      v4_mask,
	input  logic [63:0]      v6_mask_high,
	input  logic [63:0]      v6_mask_low,
	input  logic             full,
	output logic             push,
	output kfhs_pkg::entry_t wdata
);

	logic [127:0][7:0] tb;
	logic [31:0]       src4;
	logic [127:0]      src6;
	logic [127:0]      dst6;

	assign src4 = pkt.source_low[31:0] & v4_mask;
	assign src6 = {pkt.source_high & v6_mask_high, pkt.source_low & v6_mask_low};
	assign dst6 = {pkt.dest_high, pkt.dest_low};

	assign pkt.ready = !full;
	assign push = pkt.valid && !full;

	always_comb begin
		tb = '0;
		if (!pkt.mode) begin
			for (int i = 0; i < 8; i++) begin
				tb[127 - i] = kfhs_pkg::hex_char(src4[31 - 4 * i -: 4]);
				tb[118 - i] = kfhs_pkg::hex_char(pkt.dest_low[31 - 4 * i -: 4]);
				tb[64 + i] = kfhs_pkg::LEN_BITS_V4[8 * i +: 8];
			end
			tb[119] = 8'h20;
			tb[110] = 8'h20;
			for (int i = 0; i < 4; i++) begin
				tb[109 - i] = kfhs_pkg::hex_char(pkt.dest_port[15 - 4 * i -: 4]);
			end
			tb[105] = 8'h80;
		end else begin
			for (int i = 0; i < 16; i++) begin
				tb[127 - 3 * i] = kfhs_pkg::hex_char(src6[127 - 8 * i -: 4]);
				tb[126 - 3 * i] = kfhs_pkg::hex_char(src6[123 - 8 * i -: 4]);
				tb[125 - 3 * i] = 8'h20;
				tb[79 - 3 * i] = kfhs_pkg::hex_char(dst6[127 - 8 * i -: 4]);
				tb[78 - 3 * i] = kfhs_pkg::hex_char(dst6[123 - 8 * i -: 4]);
				tb[77 - 3 * i] = 8'h20;
			end
			for (int i = 0; i < 4; i++) begin
				tb[31 - i] = kfhs_pkg::hex_char(pkt.dest_port[15 - 4 * i -: 4]);
			end
			tb[27] = 8'h80;
			for (int i = 0; i < 8; i++) begin
				tb[i] = kfhs_pkg::LEN_BITS_V6[8 * i +: 8];
			end
		end
	end

	assign wdata.v6 = pkt.mode;
	assign wdata.tail = tb;

endmodule

// File: rtl/kfhs_fifo.sv
`timescale 1ns / 1ps
module kfhs_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kfhs_pkg::entry_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output kfhs_pkg::entry_t rdata
);

	kfhs_pkg::entry_t mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/kfhs_sha_core.sv
`timescale 1ns / 1ps
module kfhs_sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  kfhs_pkg::sha_req_t req,
	output kfhs_pkg::sha_rsp_t rsp
);

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		logic [31:0] r;
		r = (x >> n) | (x << (32 - n));
		return r;
	endfunction

	logic [7:0][31:0]  v_q;
	logic [7:0][31:0]  iv_q;
	logic [15:0][31:0] w_q;
	logic [5:0]        rnd_q;
	logic              busy_q;
	logic              fin_q;
	logic [31:0]       t1;
	logic [31:0]       t2;
	logic [31:0]       w_next;
	logic [31:0]       a, b, c, d, e, f, g, h;

	assign {a, b, c, d, e, f, g, h} = v_q;

	always_comb begin
		t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
			+ SHA_K[rnd_q] + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
		w_next = w_q[0]
			+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
			+ w_q[9]
			+ (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= req.init;
			iv_q <= req.init;
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= req.block[511 - 32 * i -: 32];
			end
		end else if (busy_q) begin
			v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp.done = fin_q;
		for (int i = 0; i < 8; i++) begin
			rsp.hash[255 - 32 * i -: 32] = iv_q[7 - i] + v_q[7 - i];
		end
	end

endmodule

// File: rtl/kfhs_back.sv
`timescale 1ns / 1ps
module kfhs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  kfhs_pkg::entry_t head,
	output logic             pop,
	input  logic [255:0]     key,
	input  logic [24:0]      ratio,
	kfhs_out_if.source       res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HASH = 4'b0010,
		ST_FOLD = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		BLK_IPAD    = 3'd0,
		BLK_TAIL_HI = 3'd1,
		BLK_TAIL_LO = 3'd2,
		BLK_OPAD    = 3'd3,
		BLK_OUTER   = 3'd4
	} blk_t;

	state_t             state_q;
	blk_t               blk_q;
	logic               start_q;
	logic [255:0]       hcur_q;
	logic [255:0]       inner_q;
	logic [255:0]       dig_q;
	logic [23:0]        acc_q;
	logic [5:0]         cnt_q;
	logic               out_valid_q;
	logic               out_sel_q;
	logic [23:0]        out_res_q;
	logic [24:0]        r_eff;
	logic [23:0]        acc_next;
	logic [24:0]        t;
	logic               emit;
	kfhs_pkg::sha_req_t req;
	kfhs_pkg::sha_rsp_t rsp;

	kfhs_sha_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always_comb begin
		req.start = start_q;
		req.init = hcur_q;
		req.block = '0;
		unique case (blk_q)
			BLK_IPAD: begin
				req.init = kfhs_pkg::SHA_IV;
				req.block = {key ^ {32{8'h36}}, {32{8'h36}}};
			end
			BLK_TAIL_HI: req.block = head.tail[1023:512];
			BLK_TAIL_LO: req.block = head.tail[511:0];
			BLK_OPAD: begin
				req.init = kfhs_pkg::SHA_IV;
				req.block = {key ^ {32{8'h5c}}, {32{8'h5c}}};
			end
			BLK_OUTER: req.block = {inner_q, 8'h80, 184'd0, kfhs_pkg::LEN_BITS_OUTER};
			default: req.block = '0;
		endcase
	end

	always_comb begin
		if (ratio == 25'd0) begin
			r_eff = 25'd1;
		end else if (ratio[24]) begin
			r_eff = kfhs_pkg::RATIO_LIMIT;
		end else begin
			r_eff = ratio;
		end
	end

	always_comb begin
		acc_next = acc_q;
		for (int i = 0; i < 4; i++) begin
			t = {acc_next, dig_q[255 - i]};
			if (t >= r_eff) begin
				t = t - r_eff;
			end
			acc_next = t[23:0];
		end
	end

	assign emit = (state_q == ST_EMIT) && (!out_valid_q || res.ready);
	assign pop = emit;

	always_ff @(posedge clk) begin
		if (rsp.done) begin
			hcur_q <= rsp.hash;
			if ((blk_q == BLK_TAIL_HI && !head.v6) || blk_q == BLK_TAIL_LO) begin
				inner_q <= rsp.hash;
			end
		end
		if (state_q == ST_HASH && rsp.done && blk_q == BLK_OUTER) begin
			dig_q <= rsp.hash;
			acc_q <= '0;
		end else if (state_q == ST_FOLD) begin
			dig_q <= {dig_q[251:0], 4'h0};
			acc_q <= acc_next;
		end
		if (emit) begin
			out_sel_q <= (acc_q == 24'd0);
			out_res_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blk_q <= BLK_IPAD;
			start_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						blk_q <= BLK_IPAD;
						start_q <= 1'b1;
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (rsp.done) begin
						start_q <= 1'b1;
						unique case (blk_q)
							BLK_IPAD: blk_q <= BLK_TAIL_HI;
							BLK_TAIL_HI: blk_q <= head.v6 ? BLK_TAIL_LO : BLK_OPAD;
							BLK_TAIL_LO: blk_q <= BLK_OPAD;
							BLK_OPAD: blk_q <= BLK_OUTER;
							default: begin
								start_q <= 1'b0;
								cnt_q <= '0;
								state_q <= ST_FOLD;
							end
						endcase
					end
				end
				ST_FOLD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.selected = out_sel_q;
	assign res.residue = out_res_q;

endmodule

// File: rtl/keyed_flow_hash_sampler_unit.sv
`timescale 1ns / 1ps
// Each request is started with a strobe, then runs its SHA-256 compressions on the single round
// unit: 4 compressions for IPv4, 5 for IPv6, then a fold (4 digest bits per cycle) and one load.
// A two-entry queue takes new requests, while it is not full, as the engine runs and while a
// result waits.
// Reset: asynchronous, active low; clears control and restores register defaults.
module keyed_flow_hash_sampler_unit (
	input  logic        clk,
	input  logic        arst_n,
	kfhs_in_if.sink     pkt,
	kfhs_out_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [63:0]      key_q [4];
	logic [24:0]      ratio_q;
	logic [31:0]      v4_mask_q;
	logic [63:0]      v6_mask_h_q;
	logic [63:0]      v6_mask_l_q;
	logic             push;
	logic             full;
	logic             pop;
	logic             avail;
	kfhs_pkg::entry_t wdata;
	kfhs_pkg::entry_t rdata;
	kfhs_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign idx = kfhs_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
			ratio_q <= 25'd1;
			v4_mask_q <= '1;
			v6_mask_h_q <= '1;
			v6_mask_l_q <= '1;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				kfhs_pkg::REG_KEY0: key_q[0] <= pwdata;
				kfhs_pkg::REG_KEY1: key_q[1] <= pwdata;
				kfhs_pkg::REG_KEY2: key_q[2] <= pwdata;
				kfhs_pkg::REG_KEY3: key_q[3] <= pwdata;
				kfhs_pkg::REG_RATIO: ratio_q <= pwdata[24:0];
				kfhs_pkg::REG_V4_MASK: v4_mask_q <= pwdata[31:0];
				kfhs_pkg::REG_V6_MASK_H: v6_mask_h_q <= pwdata;
				kfhs_pkg::REG_V6_MASK_L: v6_mask_l_q <= pwdata;
				default: ratio_q <= ratio_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			kfhs_pkg::REG_KEY0: prdata = key_q[0];
			kfhs_pkg::REG_KEY1: prdata = key_q[1];
			kfhs_pkg::REG_KEY2: prdata = key_q[2];
			kfhs_pkg::REG_KEY3: prdata = key_q[3];
			kfhs_pkg::REG_RATIO: prdata = {39'd0, ratio_q};
			kfhs_pkg::REG_V4_MASK: prdata = {32'd0, v4_mask_q};
			kfhs_pkg::REG_V6_MASK_H: prdata = v6_mask_h_q;
			kfhs_pkg::REG_V6_MASK_L: prdata = v6_mask_l_q;
			default: prdata = '0;
		endcase
	end

	kfhs_front u_front (
		.pkt         (pkt),
		.v4_mask     (v4_mask_q),
		.v6_mask_high(v6_mask_h_q),
		.v6_mask_low (v6_mask_l_q),
		.full        (full),
		.push        (push),
		.wdata       (wdata)
	);

	kfhs_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wdata),
		.full  (full),
		.pop   (pop),
		.avail (avail),
		.rdata (rdata)
	);

	kfhs_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.avail (avail),
		.head  (rdata),
		.pop   (pop),
		.key   ({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.ratio (ratio_q),
		.res   (res)
	);

endmodule

// File: rtl/kfhs_checker.sv
`timescale 1ns / 1ps
module kfhs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_selected,
	input logic [23:0] res_residue,
	input logic        pready
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_selected) && $stable(res_residue))
		else $error("stalled result changed");

	a_sel_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_selected == (res_residue == 24'd0)))
		else $error("selected disagrees with residue");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind keyed_flow_hash_sampler_unit kfhs_checker u_kfhs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_selected(res.selected),
	.res_residue (res.residue),
	.pready      (pready)
);
